// ===== rtl/core/tdf_pkg.sv =====
// Shared constants for the trial-division factorizer.
// No dependencies; imported by tdf_div, trial_division_factorizer and its testbench.
package tdf_pkg;

  // Width of the value that is factored; the input field is cut to this width.
  localparam int VALUE_WIDTH = 32;
  // Widths of the result fields.
  localparam int PRIME_W = 32;
  localparam int EXP_W = 5;
  // The exponent saturates at this count.
  localparam logic [EXP_W-1:0] EXP_MAX = 5'd31;
  // At most this many results leave the block for one input.
  localparam int MAX_RESULTS = 9;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_RESULTS);
  // Step counter of the bit-serial divider.
  localparam int STEP_W = $clog2(VALUE_WIDTH);

endpackage

// ===== rtl/core/tdf_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on tdf_pkg for the operand width.
module tdf_div import tdf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [VALUE_WIDTH-1:0] divisor,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] quotient,
  output logic [VALUE_WIDTH-1:0] remainder
);

  logic                   act_r, act_nxt;
  logic                   done_r, done_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic [VALUE_WIDTH-1:0] quo_r, quo_nxt;
  logic [VALUE_WIDTH-1:0] rem_r, rem_nxt;
  logic [VALUE_WIDTH-1:0] dvs_r, dvs_nxt;
  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH:0]   diff;
  logic                   fits;

  // One restoring step: shift in the next dividend bit and try to subtract.
  assign trial = {rem_r, quo_r[VALUE_WIDTH-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    act_nxt  = act_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      act_nxt  = 1'b1;
      step_nxt = STEP_W'(VALUE_WIDTH - 1);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (act_r) begin
      quo_nxt  = {quo_r[VALUE_WIDTH-2:0], fits};
      rem_nxt  = fits ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
      step_nxt = step_r - 1'b1;
      if (step_r == '0) begin
        act_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state is reset; the shift registers need none.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      act_r  <= act_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

`ifndef SYNTHESIS
  // A finished division is never reported while steps remain.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !act_r) else $error("divider done while still active");
  // The division ends exactly after the last step.
  a_done_step: assert property (@(posedge clk) disable iff (!rst_n)
    act_r && !start && step_r == '0 |=> done_r) else $error("divider missed done");
  // When the division is done, the remainder is below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> rem_r < dvs_r) else $error("remainder not below divisor");
`endif

endmodule

// ===== rtl/core/trial_division_factorizer.sv =====
// Trial-division factorizer: state machine, result buffer and output registers.
// Depends on tdf_pkg and on the bit-serial divider tdf_div.

// A value is taken when start is high and busy is low. The block divides the
// remaining value by candidates 2, 3, 4, ... with a bit-serial divider; the
// quotient of each division also decides whether the candidate squared still
// fits. For 0 or 1 busy stays low and the single beat is shown in the cycle
// right after the value is taken. Each result beat is shown for exactly one
// cycle with out_valid high, in rising prime order, and the last beat of an
// item has out_last set. The final two beats of an item can come in
// back-to-back cycles; the receiver cannot stall them.
module trial_division_factorizer import tdf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        in_value,
  output logic               busy,
  output logic               out_valid,
  output logic [PRIME_W-1:0] out_prime,
  output logic [EXP_W-1:0]   out_exponent,
  output logic               out_last
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIN,
    S_LAST
  } state_t;

  state_t                 state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] rem_r, rem_nxt;
  logic [VALUE_WIDTH-1:0] dvs_r, dvs_nxt;
  logic [EXP_W-1:0]       mult_r, mult_nxt;
  logic                   pend_v_r, pend_v_nxt;
  logic [PRIME_W-1:0]     pend_p_r, pend_p_nxt;
  logic [EXP_W-1:0]       pend_e_r, pend_e_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   ov_r, ov_nxt;
  logic [PRIME_W-1:0]     op_r, op_nxt;
  logic [EXP_W-1:0]       oe_r, oe_nxt;
  logic                   ol_r, ol_nxt;

  logic                   rec_v;
  logic [PRIME_W-1:0]     rec_p;
  logic [EXP_W-1:0]       rec_e;
  logic                   kick;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_q;
  logic [VALUE_WIDTH-1:0] div_r;
  logic [VALUE_WIDTH-1:0] masked;

  assign masked = VALUE_WIDTH'(in_value);

  tdf_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (kick),
    .dividend  (rem_nxt),
    .divisor   (dvs_nxt),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // Sequencer: one division per step, decisions taken when it finishes.
  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    mult_nxt  = mult_r;
    kick      = 1'b0;
    rec_v     = 1'b0;
    rec_p     = PRIME_W'(dvs_r);
    rec_e     = mult_r;
    case (state_r)
      S_IDLE: begin
        if (start && masked > VALUE_WIDTH'(1)) begin
          rem_nxt   = masked;
          dvs_nxt   = VALUE_WIDTH'(2);
          mult_nxt  = '0;
          kick      = 1'b1;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (div_done) begin
          if (mult_r != '0) begin
            // Inside a run of one divisor: keep dividing while it divides.
            if (div_r == '0) begin
              rem_nxt  = div_q;
              mult_nxt = (mult_r == EXP_MAX) ? mult_r : mult_r + 1'b1;
              kick     = 1'b1;
            end else begin
              rec_v    = 1'b1;
              mult_nxt = '0;
              dvs_nxt  = dvs_r + 1'b1;
              kick     = 1'b1;
            end
          end else if (dvs_r > div_q) begin
            // Candidate squared exceeds the remaining value.
            state_nxt = S_FIN;
          end else if (div_r == '0) begin
            rem_nxt  = div_q;
            mult_nxt = EXP_W'(1);
            kick     = 1'b1;
          end else begin
            dvs_nxt = dvs_r + 1'b1;
            kick    = 1'b1;
          end
        end
      end
      S_FIN: begin
        rec_v     = rem_r > VALUE_WIDTH'(1);
        rec_p     = PRIME_W'(rem_r);
        rec_e     = EXP_W'(1);
        state_nxt = S_LAST;
      end
      S_LAST: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result buffer: one result is held back until it is known whether it is
  // the last one; the output registers carry each beat for one cycle.
  always_comb begin
    pend_v_nxt = pend_v_r;
    pend_p_nxt = pend_p_r;
    pend_e_nxt = pend_e_r;
    cnt_nxt    = cnt_r;
    ov_nxt     = 1'b0;
    op_nxt     = op_r;
    oe_nxt     = oe_r;
    ol_nxt     = 1'b0;
    if (state_r == S_IDLE && start) begin
      pend_v_nxt = 1'b0;
      cnt_nxt    = '0;
      if (masked <= VALUE_WIDTH'(1)) begin
        ov_nxt = 1'b1;
        op_nxt = '0;
        oe_nxt = '0;
        ol_nxt = 1'b1;
      end
    end else if (state_r == S_LAST) begin
      ov_nxt     = pend_v_r;
      op_nxt     = pend_p_r;
      oe_nxt     = pend_e_r;
      ol_nxt     = 1'b1;
      pend_v_nxt = 1'b0;
    end else if (rec_v && cnt_r < CNT_LIMIT) begin
      if (pend_v_r) begin
        ov_nxt = 1'b1;
        op_nxt = pend_p_r;
        oe_nxt = pend_e_r;
      end
      pend_v_nxt = 1'b1;
      pend_p_nxt = rec_p;
      pend_e_nxt = rec_e;
      cnt_nxt    = cnt_r + 1'b1;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pend_v_r <= 1'b0;
      cnt_r    <= '0;
      ov_r     <= 1'b0;
      ol_r     <= 1'b0;
      rem_r    <= '0;
      dvs_r    <= '0;
      mult_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      pend_v_r <= pend_v_nxt;
      cnt_r    <= cnt_nxt;
      ov_r     <= ov_nxt;
      ol_r     <= ol_nxt;
      rem_r    <= rem_nxt;
      dvs_r    <= dvs_nxt;
      mult_r   <= mult_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_p_r <= pend_p_nxt;
    pend_e_r <= pend_e_nxt;
    op_r     <= op_nxt;
    oe_r     <= oe_nxt;
  end

  assign busy         = state_r != S_IDLE;
  assign out_valid    = ov_r;
  assign out_prime    = op_r;
  assign out_exponent = oe_r;
  assign out_last     = ol_r;

`ifndef SYNTHESIS
  // A beat that is not the last one only appears while the item is in work.
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !ol_r |-> busy) else $error("non-final beat outside of an item");
  // The divider reports completion only while the sequencer waits for it.
  a_div_run: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_RUN) else $error("unexpected divider completion");
  // Candidates never drop below two while dividing.
  a_dvs_min: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN |-> dvs_r >= VALUE_WIDTH'(2)) else $error("candidate below two");
  // The final step of an item always delivers the last beat.
  a_last_beat: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LAST |=> ov_r && ol_r) else $error("missing last beat");
  // Reset leaves no beat on the outputs.
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !ov_r) else $error("beat after reset");
`endif

endmodule

// ===== verif/trial_division_factorizer_tb.sv =====
// Self-checking testbench for trial_division_factorizer: factors each value on its own
// and compares every result beat with the prime, exponent and last flag it expects.
// Depends on tdf_pkg and on the RTL of trial_division_factorizer.
module trial_division_factorizer_tb import tdf_pkg::*;;

  // Longest stretch without any beat before the watchdog ends the run.
  localparam int WATCHDOG_LIMIT = 500_000;
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_ITEMS = 100;

  typedef struct packed {
    logic [PRIME_W-1:0] prime;
    logic [EXP_W-1:0]   exponent;
    logic               last;
  } factor_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic [31:0]        in_value = '0;
  logic               busy;
  logic               out_valid;
  logic [PRIME_W-1:0] out_prime;
  logic [EXP_W-1:0]   out_exponent;
  logic               out_last;

  factor_t pending_factors[$];
  int      fail_count = 0;
  int      quiet_cycles = 0;
  bit      idle_on = 1'b1;

  trial_division_factorizer u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_value     (in_value),
    .busy         (busy),
    .out_valid    (out_valid),
    .out_prime    (out_prime),
    .out_exponent (out_exponent),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Factor one value by trial division and queue the beats it should produce.
  function automatic void predict_factors(input logic [31:0] v);
    longint unsigned rem;
    longint unsigned div;
    int unsigned     mult;
    factor_t         found[$];
    factor_t         f;
    rem = longint'(v) & ((64'd1 << VALUE_WIDTH) - 64'd1);
    if (rem <= 1) begin
      f.prime = '0;
      f.exponent = '0;
      f.last = 1'b1;
      pending_factors = {pending_factors, f};
      return;
    end
    div = 2;
    while (div <= rem / div) begin
      if (rem % div == 0) begin
        mult = 0;
        while (rem % div == 0) begin
          if (mult < EXP_MAX) mult++;
          rem = rem / div;
        end
        if (found.size() < MAX_RESULTS) begin
          f.prime = div[PRIME_W-1:0];
          f.exponent = mult[EXP_W-1:0];
          f.last = 1'b0;
          found = {found, f};
        end
      end
      div++;
    end
    // Whatever is left above one is itself prime.
    if (rem > 1 && found.size() < MAX_RESULTS) begin
      f.prime = rem[PRIME_W-1:0];
      f.exponent = EXP_W'(1);
      f.last = 1'b0;
      found = {found, f};
    end
    found[found.size()-1].last = 1'b1;
    foreach (found[i]) pending_factors = {pending_factors, found[i]};
  endfunction

  // Build a random value, now and then 0 or 1, else from small factors and at most one
  // factor below 2^16, so that the trial divisor never has to climb far.
  function automatic logic [31:0] random_composite();
    longint unsigned v;
    longint unsigned f;
    int              k;
    v = 1;
    if ($urandom_range(0, 15) == 0) return 32'($urandom_range(0, 1));
    if ($urandom_range(0, 2) == 0) v = $urandom_range(2, 65535);
    k = $urandom_range(0, 14);
    repeat (k) begin
      f = $urandom_range(2, 255);
      if (v * f <= 64'hFFFF_FFFF) v = v * f;
    end
    return v[31:0];
  endfunction

  // Offer one value, wait until the block takes it, then queue its results.
  task automatic send_value(input logic [31:0] v);
    int gap;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      @(negedge clk) start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (busy);
    predict_factors(v);
  endtask

  // Stop offering values and wait for every queued result beat.
  task automatic hold_until_drained();
    @(negedge clk) start <= 1'b0;
    while (pending_factors.size() != 0) @(posedge clk);
  endtask

  task automatic test_trivial_inputs();
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'd0);
  endtask

  task automatic test_primes();
    send_value(32'd2);
    send_value(32'd3);
    send_value(32'd251);
    send_value(32'd65521);
    send_value(32'd1000003);
  endtask

  task automatic test_prime_powers();
    // Two to the 31st reaches the largest exponent and sets the top bit.
    send_value(32'h8000_0000);
    send_value(32'd3486784401);
    send_value(32'd63001);
    send_value(32'd4);
  endtask

  task automatic test_many_factors();
    // All ones is 3 * 5 * 17 * 257 * 65537.
    send_value(32'hFFFF_FFFF);
    // Product of the first nine primes gives the most result beats.
    send_value(32'd223092870);
    send_value(32'd4294967290 / 2 * 0 + 32'd3 * 32'd65537 * 32'd5);
    send_value(32'hFFFF_FFFE / 32'd2 * 32'd0 + 32'd4290772992);
  endtask

  task automatic test_random_values();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 20 == 0) idle_on = $urandom_range(0, 2) != 0;
      if (i == RANDOM_ITEMS / 2) hold_until_drained();
      send_value(random_composite());
    end
  endtask

  // Check each result beat against the oldest expected factor.
  always @(posedge clk) begin
    factor_t want;
    if (rst_n && out_valid) begin
      if (pending_factors.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got prime %0d exponent %0d last %0b",
                 $time, out_prime, out_exponent, out_last);
        fail_count++;
      end else begin
        want = pending_factors.pop_front();
        if (out_prime !== want.prime) begin
          $display("%0t: prime mismatch, expected %0d, got %0d", $time, want.prime, out_prime);
          fail_count++;
        end
        if (out_exponent !== want.exponent) begin
          $display("%0t: exponent mismatch, expected %0d, got %0d",
                   $time, want.exponent, out_exponent);
          fail_count++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last mismatch, expected %0b, got %0b", $time, want.last, out_last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run if no beat moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_trivial_inputs();
    test_primes();
    hold_until_drained();
    test_prime_powers();
    test_many_factors();
    test_random_values();
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
